[src/sat_pkg.sv]
// Package for the segment address translation block: widths, status codes, types.
// No dependencies.
package sat_pkg;
  localparam int DataW = 32;
  localparam int DefTableEntries = 16;
  localparam int SlotW = 4;
  localparam logic [DataW-1:0] MaxSegReset = 32'd4096;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFault = 2'd2;
  localparam logic [0:0] AddrMaxSeg = 1'b0;

  typedef struct packed {
    logic             mode;
    logic [SlotW-1:0] slot;
    logic [DataW-1:0] entry_id;
    logic [DataW-1:0] entry_base;
    logic [DataW-1:0] entry_size;
    logic             entry_valid;
    logic [DataW-1:0] logical_address;
    logic [DataW-1:0] access_size;
  } sat_in_t;

  typedef struct packed {
    logic [DataW-1:0] physical_address;
    logic [1:0]       status;
  } sat_out_t;
endpackage

[src/sat_if.sv]
// Valid/ready channel interfaces for the segment address translation block.
// Depends on sat_pkg.
interface sat_in_if import sat_pkg::*; ();
  logic    valid;
  logic    ready;
  sat_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sat_out_if import sat_pkg::*; ();
  logic     valid;
  logic     ready;
  sat_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/sat_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, with payload carried along.
// Depends on sat_pkg.
module sat_divider import sat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  sat_in_t          in_item,
  input  logic [DataW-1:0] divisor,
  output logic             out_vld,
  output sat_in_t          out_item,
  output logic [DataW-1:0] quot,
  output logic [DataW-1:0] rem
);
  // Stage k holds the partial remainder after k quotient bits.
  logic             vld_r  [DataW+1];
  sat_in_t          item_r [DataW+1];
  logic [DataW-1:0] div_r  [DataW+1];
  logic [DataW-1:0] q_r    [DataW+1];
  logic [DataW-1:0] rm_r   [DataW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DataW; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k <= DataW; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r[0] <= in_item;
      div_r[0]  <= divisor;
      q_r[0]    <= in_item.logical_address;
      rm_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= DataW; k++) begin : g_stage
    logic [DataW:0] trial;
    logic [DataW:0] diff;
    assign trial = {rm_r[k-1], q_r[k-1][DataW-1]};
    assign diff  = trial - {1'b0, div_r[k-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        item_r[k] <= item_r[k-1];
        div_r[k]  <= div_r[k-1];
        if (!diff[DataW]) begin
          rm_r[k] <= diff[DataW-1:0];
          q_r[k]  <= {q_r[k-1][DataW-2:0], 1'b1};
        end else begin
          rm_r[k] <= trial[DataW-1:0];
          q_r[k]  <= {q_r[k-1][DataW-2:0], 1'b0};
        end
      end
    end
  end

  // A zero divisor yields all ones and a remainder equal to the dividend.
  assign out_vld  = vld_r[DataW];
  assign out_item = item_r[DataW];
  assign quot     = q_r[DataW];
  assign rem      = (div_r[DataW] == '0) ? item_r[DataW].logical_address : rm_r[DataW];
endmodule

[src/segment_address_translation.sv]
// Segment address translation: a write item loads one table slot; a translate item
// divides the address by max_segment_size, looks the quotient up among the slots and
// returns base plus offset or a status. The pipeline is a 33-stage divider, a
// compare stage, a select stage and the output register; one item enters per cycle.
// While a result waits at the output the whole pipeline holds, and the input with it.
// A write item commits to the table as it leaves the select stage. The id compare for
// a translation sees the two writes just ahead of it through forwarding, and the base
// and size are read in the select stage, after every earlier write has committed.
// Depends on sat_pkg, sat_if and sat_divider.
module segment_address_translation import sat_pkg::*; #(
  parameter int TABLE_ENTRIES = DefTableEntries
) (
  input  logic         clk,
  input  logic         rst_n,
  sat_in_if.sink       in_ch,
  sat_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [DataW-1:0] max_seg_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) max_seg_r <= MaxSegReset;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == AddrMaxSeg)
      max_seg_r <= cfg_pwdata;
  end
  assign cfg_prdata = (cfg_paddr[2] == AddrMaxSeg) ? max_seg_r : '0;

  // Table in flip-flops; valid bits reset, payload does not need to.
  logic [DataW-1:0]   ids_r   [TABLE_ENTRIES];
  logic [DataW-1:0]   bases_r [TABLE_ENTRIES];
  logic [DataW-1:0]   sizes_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic out_vld_r;
  logic adv;
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic             d_vld;
  sat_in_t          d_item;
  logic [DataW-1:0] d_quot, d_rem;

  sat_divider u_div (
    .clk, .rst_n, .adv,
    .in_vld  (in_ch.valid),
    .in_item (in_ch.data),
    .divisor (max_seg_r),
    .out_vld (d_vld),
    .out_item(d_item),
    .quot    (d_quot),
    .rem     (d_rem)
  );

  // Compare stage: writes of the preceding items in stages c and s are forwarded here.
  logic                     c_vld_r;
  logic                     c_mode_r;
  logic [TABLE_ENTRIES-1:0] c_hit_r;
  logic [DataW-1:0]         c_rem_r;
  logic [DataW:0]           c_end_r;
  logic                     c_wr_en_r;
  logic [IdxW-1:0]          c_wr_idx_r;
  sat_in_t                  c_wr_r;

  logic                     s_vld_r;
  logic                     s_mode_r;
  logic                     s_wr_en_r;
  logic [IdxW-1:0]          s_wr_idx_r;
  sat_in_t                  s_wr_r;
  logic [TABLE_ENTRIES-1:0] s_hit_r;
  logic [DataW-1:0]         s_rem_r;
  logic [DataW:0]           s_end_r;

  logic [TABLE_ENTRIES-1:0] hit_nxt;
  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      hit_nxt[k] = valid_r[k] && ids_r[k] == d_quot;
      if (s_vld_r && s_wr_en_r && s_wr_idx_r == IdxW'(k))
        hit_nxt[k] = s_wr_r.entry_valid && s_wr_r.entry_id == d_quot;
      // The write in c is newer than the one in s, so it is applied last.
      if (c_vld_r && c_wr_en_r && c_wr_idx_r == IdxW'(k))
        hit_nxt[k] = c_wr_r.entry_valid && c_wr_r.entry_id == d_quot;
    end
  end

  logic wr_ok;
  assign wr_ok = {{(DataW-SlotW){1'b0}}, d_item.slot} < DataW'(TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= d_vld;
      s_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_mode_r   <= d_item.mode;
      c_hit_r    <= hit_nxt;
      c_rem_r    <= d_rem;
      c_end_r    <= {1'b0, d_rem} + {1'b0, d_item.access_size};
      c_wr_en_r  <= !d_item.mode && wr_ok;
      c_wr_idx_r <= IdxW'(d_item.slot);
      c_wr_r     <= d_item;
      s_mode_r   <= c_mode_r;
      s_hit_r    <= c_hit_r;
      s_rem_r    <= c_rem_r;
      s_end_r    <= c_end_r;
      s_wr_en_r  <= c_wr_en_r;
      s_wr_idx_r <= c_wr_idx_r;
      s_wr_r     <= c_wr_r;
    end
  end

  // Writes commit from stage s. Every write ahead of a lookup was either in the table
  // or forwarded from c or s when its hit vector was formed.
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (adv && s_vld_r && s_wr_en_r) valid_r[s_wr_idx_r] <= s_wr_r.entry_valid;
  end
  always_ff @(posedge clk) begin
    if (adv && s_vld_r && s_wr_en_r) begin
      ids_r[s_wr_idx_r]   <= s_wr_r.entry_id;
      bases_r[s_wr_idx_r] <= s_wr_r.entry_base;
      sizes_r[s_wr_idx_r] <= s_wr_r.entry_size;
    end
  end

  // Select stage: lowest hit slot; base and size already hold all earlier writes.
  logic [DataW-1:0] pa_nxt;
  logic [1:0]       st_nxt;
  logic [TABLE_ENTRIES-1:0] hit_fix;
  always_comb begin
    logic found;
    logic [DataW-1:0] b, sz;
    found = 1'b0;
    b = '0;
    sz = '0;
    hit_fix = s_hit_r;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (!found && hit_fix[k]) begin
        found = 1'b1;
        b = bases_r[k];
        sz = sizes_r[k];
      end
    end
    if (!s_mode_r) begin
      pa_nxt = '0;
      st_nxt = StOk;
    end else if (!found) begin
      pa_nxt = '0;
      st_nxt = StNotFound;
    end else if (s_end_r > {1'b0, sz}) begin
      pa_nxt = '0;
      st_nxt = StFault;
    end else begin
      pa_nxt = b + s_rem_r;
      st_nxt = StOk;
    end
  end

  sat_out_t out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= s_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.physical_address <= pa_nxt;
      out_r.status           <= st_nxt;
    end
  end
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;
endmodule

[sim/segment_address_translation_tb.sv]
// Testbench for segment_address_translation: directed table, then random items,
// all checked against a behavioral predictor of the segment table and divider.
// Depends on sat_pkg, sat_if and the block's RTL.
`timescale 1ns / 1ps

module segment_address_translation_tb;
  import sat_pkg::*;

  localparam int NumSlots = 16;
  localparam int PipeLat = 36;
  localparam int RandItems = 1650;

  typedef struct {
    sat_in_t  item;
    logic     known;
    sat_out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sat_in_if in_ch ();
  sat_out_if out_ch ();

  segment_address_translation u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // Predictor state.
  logic [31:0] seg_div;
  logic [31:0] tbl_id [NumSlots];
  logic [31:0] tbl_base [NumSlots];
  logic [31:0] tbl_size [NumSlots];
  logic        tbl_valid [NumSlots];

  sat_out_t pending_xlat[$];
  int errors = 0;
  bit hold_long = 1'b0;

  function automatic sat_out_t translate_item(sat_in_t it);
    sat_out_t r;
    logic [31:0] segno, off;
    logic [32:0] span;
    int hit;
    r.physical_address = '0;
    r.status = StOk;
    hit = -1;
    if (it.mode == 1'b0) begin
      tbl_id[it.slot] = it.entry_id;
      tbl_base[it.slot] = it.entry_base;
      tbl_size[it.slot] = it.entry_size;
      tbl_valid[it.slot] = it.entry_valid;
      return r;
    end
    if (seg_div == 0) begin
      segno = '1;
      off = it.logical_address;
    end else begin
      segno = it.logical_address / seg_div;
      off = it.logical_address % seg_div;
    end
    for (int k = NumSlots - 1; k >= 0; k--)
      if (tbl_valid[k] && tbl_id[k] == segno) hit = k;
    if (hit < 0) begin
      r.status = StNotFound;
    end else begin
      span = {1'b0, off} + {1'b0, it.access_size};
      if (span > {1'b0, tbl_size[hit]}) r.status = StFault;
      else r.physical_address = tbl_base[hit] + off;
    end
    return r;
  endfunction

  function automatic sat_in_t load_item(logic [3:0] s, logic [31:0] id, logic [31:0] base,
                                        logic [31:0] size, logic v);
    sat_in_t it;
    it = '0;
    it.mode = 1'b0;
    it.slot = s;
    it.entry_id = id;
    it.entry_base = base;
    it.entry_size = size;
    it.entry_valid = v;
    return it;
  endfunction

  function automatic sat_in_t xlat_item(logic [31:0] la, logic [31:0] acc);
    sat_in_t it;
    it = '0;
    it.mode = 1'b1;
    it.logical_address = la;
    it.access_size = acc;
    return it;
  endfunction

  // Random noise in the unused fields, so every input bit toggles.
  function automatic sat_in_t rand_item(logic [31:0] span);
    sat_in_t it;
    logic [3:0] s;
    it = sat_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    s = 4'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      it.mode = 1'b0;
      it.slot = s;
      if ($urandom_range(0, 9) != 0) it.entry_id = $urandom_range(0, 5);
      if ($urandom_range(0, 3) != 0) it.entry_size = $urandom_range(0, span);
      it.entry_valid = ($urandom_range(0, 4) != 0);
    end else begin
      it.mode = 1'b1;
      if (seg_div != 0 && $urandom_range(0, 9) != 0)
        it.logical_address = $urandom_range(0, 5) * seg_div + $urandom_range(0, seg_div - 1);
      if ($urandom_range(0, 3) != 0) it.access_size = $urandom_range(0, span);
    end
    return it;
  endfunction

  task automatic send_item(sat_in_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    pending_xlat.push_back(translate_item(it));
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3))
        @(negedge clk);
    end
  endtask

  task automatic write_max_seg(logic [31:0] v);
    in_ch.valid <= 1'b0;
    while (pending_xlat.size() != 0) @(negedge clk);
    repeat (PipeLat) @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {AddrMaxSeg, 2'b00};
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    seg_div = v;
  endtask

  // Result checking.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_xlat.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_ch.data);
        errors++;
      end else begin
        sat_out_t w;
        w = pending_xlat.pop_front();
        if (out_ch.data.physical_address !== w.physical_address) begin
          $display("%0t: physical_address expected %h actual %h", $time,
                   w.physical_address, out_ch.data.physical_address);
          errors++;
        end
        if (out_ch.data.status !== w.status) begin
          $display("%0t: status expected %0d actual %0d", $time, w.status,
                   out_ch.data.status);
          errors++;
        end
      end
    end
  end

  // Receiver stalls, with one long hold-off to back up the pipeline.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (150) @(negedge clk);
        hold_long = 1'b0;
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3))
          @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    sat_out_t r;
    logic [31:0] divs[6];
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    seg_div = MaxSegReset;
    for (int k = 0; k < NumSlots; k++) begin
      tbl_id[k] = '0;
      tbl_base[k] = '0;
      tbl_size[k] = '0;
      tbl_valid[k] = 1'b0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows: empty table misses, loads, hits, faults, duplicates, wrap.
    rows.push_back('{xlat_item(32'h0, 32'h0), 1'b1, '{32'h0, StNotFound}});
    rows.push_back('{xlat_item(32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, '{32'h0, StNotFound}});
    rows.push_back('{load_item(4'd0, 32'd1, 32'h1000_0000, 32'd4096, 1'b1), 1'b1,
                     '{32'h0, StOk}});
    rows.push_back('{xlat_item(32'h1010, 32'h10), 1'b1, '{32'h1000_0010, StOk}});
    rows.push_back('{xlat_item(32'h1FFF, 32'h1), 1'b1, '{32'h1000_0FFF, StOk}});
    rows.push_back('{xlat_item(32'h1FFF, 32'h2), 1'b1, '{32'h0, StFault}});
    rows.push_back('{xlat_item(32'h1000, 32'hFFFF_FFFF), 1'b1, '{32'h0, StFault}});
    rows.push_back('{load_item(4'd15, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b0,
                     '{32'h0, StOk}});
    rows.push_back('{xlat_item(32'h1001, 32'h0), 1'b0, '{32'h0, StOk}});
    rows.push_back('{load_item(4'd0, 32'd1, 32'h0, 32'h0, 1'b0), 1'b0, '{32'h0, StOk}});
    rows.push_back('{xlat_item(32'h1001, 32'h0), 1'b0, '{32'h0, StOk}});
    rows.push_back('{load_item(4'd7, 32'h000F_FFFF, 32'hFFFF_F000, 32'hFFFF_FFFF, 1'b1),
                     1'b0, '{32'h0, StOk}});
    rows.push_back('{xlat_item(32'hFFFF_FFFF, 32'h0), 1'b0, '{32'h0, StOk}});
    rows.push_back('{xlat_item(32'hFFFF_F000, 32'hFFFF_FFFF), 1'b0, '{32'h0, StOk}});
    rows.push_back('{load_item(4'd3, 32'hFFFF_FFFF, 32'h8, 32'hFFFF_FFFF, 1'b1), 1'b0,
                     '{32'h0, StOk}});
    foreach (rows[i]) begin
      r = translate_item(rows[i].item);
      if (rows[i].known && r !== rows[i].want) begin
        $display("%0t: directed row %0d expected %h actual %h", $time, i, rows[i].want, r);
        errors++;
      end
      // translate_item has already updated the table, so undo by rebuilding below.
    end
    // Restore predictor state and replay through the block.
    for (int k = 0; k < NumSlots; k++) begin
      tbl_id[k] = '0;
      tbl_base[k] = '0;
      tbl_size[k] = '0;
      tbl_valid[k] = 1'b0;
    end
    foreach (rows[i]) send_item(rows[i].item);

    // Zero divisor: the segment number is all ones and the offset is the address.
    write_max_seg(32'h0);
    send_item(xlat_item(32'h0000_0010, 32'h0));
    send_item(xlat_item(32'hFFFF_FFF0, 32'h10));
    hold_long = 1'b1;
    divs = '{32'd1, 32'd4096, 32'hFFFF_FFFF, 32'd7, 32'h0, 32'h0001_0000};
    for (int p = 0; p < 6; p++) begin
      logic [31:0] span;
      write_max_seg(divs[p]);
      span = (divs[p] == 0 || divs[p] > 32'h1_0000) ? 32'hFFFF_FFFF : 2 * divs[p];
      for (int n = 0; n < RandItems / 6; n++) send_item(rand_item(span));
    end
    in_ch.valid <= 1'b0;
    while (pending_xlat.size() != 0) @(negedge clk);
    repeat (PipeLat + 10) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
